>>> rtl/dcnf_pkg.sv
package dcnf_pkg;

    // Width of the magnitude field on the result channel
    localparam int MAG_W = 24;

    // Token kinds on the result channel
    localparam logic [1:0] TOK_LITERAL    = 2'd0;
    localparam logic [1:0] TOK_CLAUSE_END = 2'd1;
    localparam logic [1:0] TOK_VAR_COUNT  = 2'd2;
    localparam logic [1:0] TOK_END        = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       final_byte;
    } in_t;

    typedef struct packed {
        logic [1:0]       token_kind;
        logic [MAG_W-1:0] magnitude;
        logic             negative;
        logic             overflowed;
        logic             run_end;
    } out_t;

    // Results pushed by the parser for one byte
    typedef struct packed {
        logic [1:0] cnt;
        out_t       item0;
        out_t       item1;
    } push_t;

endpackage

>>> rtl/dcnf_parse.sv
module dcnf_parse #(
    parameter int INDEX_BITS = 24
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           take,
    input  dcnf_pkg::in_t  in_item,
    output dcnf_pkg::push_t push
);
    import dcnf_pkg::*;

    // Parser modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_SIGN    = 4'd2;
    localparam logic [3:0] M_NUM     = 4'd3;
    localparam logic [3:0] M_HDR     = 4'd4;
    localparam logic [3:0] M_HDR_C   = 4'd5;
    localparam logic [3:0] M_HDR_CN  = 4'd6;
    localparam logic [3:0] M_HDR_WS  = 4'd7;
    localparam logic [3:0] M_HDR_NUM = 4'd8;
    localparam logic [3:0] M_DONE    = 4'd9;

    // Character codes
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_F     = 8'h66;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;

    localparam int                    PW      = INDEX_BITS + 4;
    localparam logic [INDEX_BITS-1:0] MAX_IDX = '1;

    logic [3:0]            mode_reg, mode_next;
    logic [INDEX_BITS-1:0] acc_reg, acc_next;
    logic                  minus_reg, minus_next;
    logic                  sat_reg, sat_next;

    logic [3:0]            mode_a;
    logic [INDEX_BITS-1:0] acc_a;
    logic                  minus_a, sat_a;

    logic [7:0]            b;
    logic                  is_dig, is_lf, is_hws;
    logic                  cont;
    logic [INDEX_BITS-1:0] base;
    logic [PW-1:0]         prod;
    logic                  ovf;
    logic [INDEX_BITS-1:0] acc_calc;
    logic                  sat_calc;

    logic                  sw_emit, ended, fin_emit, end_emit;
    out_t                  sw_tok, fin_tok, end_tok;

    function automatic out_t num_tok(logic [INDEX_BITS-1:0] a, logic neg, logic sat);
        out_t t;
        t = '0;
        if (a == '0) begin
            t.token_kind = TOK_CLAUSE_END;
        end else begin
            t.token_kind = TOK_LITERAL;
            t.magnitude  = MAG_W'(a);
            t.negative   = neg;
            t.overflowed = sat;
        end
        return t;
    endfunction

    function automatic out_t cnt_tok(logic [INDEX_BITS-1:0] a, logic sat);
        out_t t;
        t = '0;
        t.token_kind = TOK_VAR_COUNT;
        t.magnitude  = MAG_W'(a);
        t.overflowed = sat;
        return t;
    endfunction

    // Decode the byte and run one multiply-by-ten accumulate
    always_comb begin
        b      = in_item.text_byte;
        is_dig = (b >= CH_0) && (b <= CH_9);
        is_lf  = (b == CH_LF);
        is_hws = (b == CH_SP) || (b == CH_TAB);

        cont     = (mode_reg == M_NUM) || (mode_reg == M_HDR_NUM);
        base     = cont ? acc_reg : '0;
        prod     = (PW'(base) << 3) + (PW'(base) << 1) + PW'(b[3:0]);
        ovf      = prod > PW'(MAX_IDX);
        acc_calc = ovf ? MAX_IDX : prod[INDEX_BITS-1:0];
        sat_calc = (cont & sat_reg) | ovf;
    end

    // Advance the mode for one byte
    always_comb begin
        mode_a  = mode_reg;
        acc_a   = acc_reg;
        minus_a = minus_reg;
        sat_a   = sat_reg;
        sw_emit = 1'b0;
        sw_tok  = '0;
        ended   = 1'b0;
        end_tok = '0;
        end_tok.token_kind = TOK_END;

        unique case (mode_reg)
            M_COMMENT: begin
                if (is_lf) mode_a = M_IDLE;
            end
            M_SIGN: begin
                if (is_dig) begin
                    acc_a  = acc_calc;
                    sat_a  = sat_calc;
                    mode_a = M_NUM;
                end else begin
                    mode_a = M_IDLE;
                end
            end
            M_NUM: begin
                if (is_dig) begin
                    acc_a = acc_calc;
                    sat_a = sat_calc;
                end else begin
                    sw_emit = 1'b1;
                    sw_tok  = num_tok(acc_reg, minus_reg, sat_reg);
                    mode_a  = M_IDLE;
                end
            end
            M_HDR: begin
                if (b == CH_C) mode_a = M_HDR_C;
                else           mode_a = is_lf ? M_IDLE : M_HDR;
            end
            M_HDR_C: begin
                if (b == CH_N) mode_a = M_HDR_CN;
                else           mode_a = is_lf ? M_IDLE : M_HDR;
            end
            M_HDR_CN: begin
                if (b == CH_F) mode_a = M_HDR_WS;
                else           mode_a = is_lf ? M_IDLE : M_HDR;
            end
            M_HDR_WS: begin
                if (is_hws) begin
                    mode_a = M_HDR_WS;
                end else if (is_dig) begin
                    acc_a  = acc_calc;
                    sat_a  = sat_calc;
                    mode_a = M_HDR_NUM;
                end else begin
                    mode_a = is_lf ? M_IDLE : M_HDR;
                end
            end
            M_HDR_NUM: begin
                if (is_dig) begin
                    acc_a = acc_calc;
                    sat_a = sat_calc;
                end else begin
                    sw_emit = (acc_reg != '0);
                    sw_tok  = cnt_tok(acc_reg, sat_reg);
                    mode_a  = is_lf ? M_IDLE : M_HDR;
                end
            end
            M_DONE: begin
                ended = 1'b1;
            end
            default: begin
                // Between tokens; unused codes land here as well
                if (is_hws || b == CH_CR || is_lf) begin
                    mode_a = M_IDLE;
                end else if (b == CH_C) begin
                    mode_a = M_COMMENT;
                end else if (b == CH_PCT) begin
                    sw_emit = 1'b1;
                    sw_tok  = end_tok;
                    ended   = 1'b1;
                    mode_a  = M_DONE;
                end else if (b == CH_P) begin
                    mode_a = M_HDR;
                end else if (b == CH_MINUS) begin
                    minus_a = 1'b1;
                    mode_a  = M_SIGN;
                end else if (b == CH_PLUS) begin
                    minus_a = 1'b0;
                    mode_a  = M_SIGN;
                end else if (is_dig) begin
                    minus_a = 1'b0;
                    acc_a   = acc_calc;
                    sat_a   = sat_calc;
                    mode_a  = M_NUM;
                end else begin
                    mode_a = M_IDLE;
                end
            end
        endcase
    end

    // Flush a pending number and close the run on the final byte
    always_comb begin
        fin_emit = 1'b0;
        fin_tok  = '0;
        if (in_item.final_byte) begin
            if (mode_a == M_NUM) begin
                fin_emit = 1'b1;
                fin_tok  = num_tok(acc_a, minus_a, sat_a);
            end else if (mode_a == M_HDR_NUM) begin
                fin_emit = (acc_a != '0);
                fin_tok  = cnt_tok(acc_a, sat_a);
            end
        end
        end_emit = in_item.final_byte && !ended;

        push = '0;
        if (take) begin
            if (sw_emit || fin_emit) begin
                push.item0 = sw_emit ? sw_tok : fin_tok;
                push.item1 = end_tok;
                push.cnt   = end_emit ? 2'd2 : 2'd1;
            end else if (end_emit) begin
                push.item0 = end_tok;
                push.cnt   = 2'd1;
            end
        end
        push.item0.run_end = (push.cnt == 2'd1);
        push.item1.run_end = 1'b1;
    end

    // Hold state while no byte is taken, advance it on a taken byte; drop back to reset after the final byte
    always_comb begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        minus_next = minus_reg;
        sat_next   = sat_reg;
        if (take) begin
            if (in_item.final_byte) begin
                mode_next  = M_IDLE;
                acc_next   = '0;
                minus_next = 1'b0;
                sat_next   = 1'b0;
            end else begin
                mode_next  = mode_a;
                acc_next   = acc_a;
                minus_next = minus_a;
                sat_next   = sat_a;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            acc_reg   <= '0;
            minus_reg <= 1'b0;
            sat_reg   <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            minus_reg <= minus_next;
            sat_reg   <= sat_next;
        end
    end

endmodule

>>> rtl/dcnf_queue.sv
module dcnf_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  dcnf_pkg::push_t push,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output dcnf_pkg::out_t  m_data
);
    import dcnf_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;

    out_t          slot_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pop;

    // Room for the two results one byte can cause
    assign room    = cnt_reg <= CW'(DEPTH - 2);
    assign m_valid = cnt_reg != '0;
    assign m_data  = slot_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        cnt_next    = cnt_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store up to two results per transfer
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            slot_reg[wr_ptr_reg] <= push.item0;
        end
        if (push.cnt == 2'd2) begin
            slot_reg[wr_ptr_reg + AW'(1)] <= push.item1;
        end
    end

endmodule

>>> rtl/dimacs_cnf_token_parser.sv
// Latency: results of a byte are offered on m_ the cycle after its transfer when
// no earlier results still wait in the queue.
// Throughput: one byte per cycle; a byte causes at most two results, which leave
// through a four-entry result queue at one per cycle while m_ready is high, and
// s_ready drops while fewer than two entries are free.
// Reset: aresetn is synchronous, active low; it empties the queue and returns
// the parser to its between-tokens mode with a cleared number.
module dimacs_cnf_token_parser #(
    parameter int INDEX_BITS = 24
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  dcnf_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output dcnf_pkg::out_t m_data
);
    import dcnf_pkg::*;

    logic  take;
    push_t push;

    assign take = s_valid && s_ready;

    // Parse one byte per transfer
    dcnf_parse #(
        .INDEX_BITS (INDEX_BITS)
    ) u_parse (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .in_item (s_data),
        .push    (push)
    );

    // Queue results towards the output channel
    dcnf_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
